### hw/rtl/hea_pkg.sv
// Package for the histogram entropy accumulator.
// Holds the shared queue entry type and fixed constants; no dependencies.
package hea_pkg;
    localparam int SUM_BITS = 40;
    localparam int SUM_FRAC = 32;
    localparam int OUT_BITS = 21;
    localparam int CNT_W    = 32;

    // One classified bin handed from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic             work;   // term must be computed
        logic             err;    // bin is an error
        logic             last;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_LOGN, S_LOGC, S_MUL, S_ACC, S_OUT
    } t_state;
endpackage

### hw/rtl/hea_front.sv
// Front end: accepts bins, classifies them and writes a two-entry queue.
// Depends on hea_pkg.
module hea_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic [31:0]          i_total,
    output logic                 o_q_valid,
    output hea_pkg::t_entry      o_q_data,
    input  logic                 i_q_pop
);
    import hea_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_entry     w_ent;
    logic [CNT_W-1:0] w_c, w_n;
    logic       w_push;

    // Classify the bin against the current total.
    always_comb begin
        w_c = CNT_W'(s_axis_tdata[COUNT_BITS-1:0]);
        w_n = CNT_W'(i_total[COUNT_BITS-1:0]);
        w_ent.count = w_c;
        w_ent.total = w_n;
        w_ent.err   = (w_n == '0) || (w_c > w_n);
        w_ent.work  = !w_ent.err && (w_c != '0) && (w_c != w_n);
        w_ent.last  = s_axis_tlast;
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push = s_axis_tvalid && s_axis_tready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_ent;
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

### hw/rtl/hea_back.sv
// Back end: serial divide, serial log2, term multiply, accumulate and output.
// Depends on hea_pkg.
module hea_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  hea_pkg::t_entry      i_q_data,
    output logic                 o_q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,
    output logic                 o_busy
);
    import hea_pkg::*;
    localparam int SH = SUM_FRAC - FRAC_BITS;

    t_state r_st, n_st;
    t_entry r_e;
    logic [5:0]  r_i;
    logic [63:0] r_rem;
    logic [32:0] r_p;
    logic [31:0] r_m;
    logic [31:0] r_frac;
    logic [36:0] r_ln, r_lc;
    logic [63:0] r_prod;
    logic [SUM_BITS-1:0] r_sum;
    logic        r_err;
    logic [OUT_BITS-1:0] r_out;
    logic        r_oerr, r_ovalid;

    logic [4:0]  w_k;
    logic [63:0] w_sq;
    logic [32:0] w_sqs;
    logic [64:0] w_sub;
    logic [36:0] w_d;
    logic [SUM_BITS:0] w_acc;
    logic [SUM_BITS:0] w_rnd;
    logic [SUM_BITS:0] w_shr;
    logic [31:0] w_x;

    // Operand for the log2 unit.
    assign w_x = (r_st == S_LOGN) ? r_e.total : r_e.count;

    // Leading one position.
    always_comb begin
        w_k = '0;
        for (int b = 0; b < 32; b++) if (w_x[b]) w_k = 5'(b);
    end

    // Mantissa squaring step, divide subtract, log difference, sum, rounding.
    always_comb begin
        w_sq  = 64'(r_m) * 64'(r_m);
        w_sqs = w_sq[63:31];
        w_sub = {r_rem, 1'b0} - {33'd0, r_e.total};
        w_d   = (r_ln > r_lc) ? (r_ln - r_lc) : '0;
        w_acc = {1'b0, r_sum} + (SUM_BITS+1)'(r_prod[63:32]);
        w_rnd = {1'b0, r_sum} + ((SUM_BITS+1)'(1) << (SH - 1));
        w_shr = w_rnd >> SH;
    end

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;
    assign o_busy  = (r_st != S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b0, r_oerr, r_out};

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_q_valid) n_st = i_q_data.work ? S_DIV : S_ACC;
            S_DIV:  if (r_i == 6'd32) n_st = S_LOGN;
            S_LOGN: if (r_i == 6'd33) n_st = S_LOGC;
            S_LOGC: if (r_i == 6'd33) n_st = S_MUL;
            S_MUL:  if (r_i == 6'd1) n_st = S_ACC;
            S_ACC:  n_st = r_e.last ? S_OUT : S_IDLE;
            S_OUT:  if (!r_ovalid || m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_sum <= '0; r_err <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_ACC) begin
                if (r_e.err) r_err <= 1'b1;
                else if (r_e.work)
                    r_sum <= w_acc[SUM_BITS] ? '1 : w_acc[SUM_BITS-1:0];
            end
            if (r_st == S_OUT && n_st == S_IDLE) begin
                r_ovalid <= 1'b1; r_sum <= '0; r_err <= 1'b0;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (n_st != r_st) r_i <= '0;
        else r_i <= r_i + 6'd1;
        unique case (r_st)
            S_IDLE: if (i_q_valid) begin
                r_e <= i_q_data; r_rem <= {32'd0, i_q_data.count}; r_p <= '0;
            end
            S_DIV: if (r_i < 6'd33) begin
                // restoring divide of count*2^32 by total, one bit a cycle
                if (r_i == 6'd32) begin
                    r_p <= r_p;
                end else if (!w_sub[64]) begin
                    r_rem <= w_sub[63:0]; r_p <= {r_p[31:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[62:0], 1'b0}; r_p <= {r_p[31:0], 1'b0};
                end
            end
            S_LOGN, S_LOGC: begin
                if (r_i == 6'd0) begin
                    r_m <= w_x << (5'd31 - w_k); r_frac <= '0;
                end else if (r_i <= 6'd32) begin
                    r_frac <= {r_frac[30:0], w_sqs[32]};
                    r_m <= w_sqs[32] ? w_sqs[32:1] : w_sqs[31:0];
                end else if (r_st == S_LOGN) r_ln <= {w_k, r_frac};
                else r_lc <= {w_k, r_frac};
            end
            S_MUL: begin
                if (r_i == 6'd0)
                    r_prod <= 64'(r_p) * 64'(w_d[31:0]);
                else
                    r_prod <= r_prod + (64'(r_p) * 64'(w_d[36:32]) << 32);
            end
            S_OUT: if (n_st == S_IDLE) begin
                r_oerr <= r_err;
                if (r_err) r_out <= '0;
                else if (w_shr > (SUM_BITS+1)'({OUT_BITS{1'b1}})) r_out <= '1;
                else r_out <= w_shr[OUT_BITS-1:0];
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/histogram_entropy_accumulator.sv
// Top level of the histogram entropy accumulator.
// Depends on hea_pkg, hea_front and hea_back.
//
// Usage: stream one bin count per transaction on s_axis (tdata = bin_count,
// tlast = last_bin). Write the sample total through i_cfg_we/i_cfg_wdata
// while idle; reset value is 1. On a last bin one result transaction leaves
// on m_axis: tdata[20:0] entropy_q16, tdata[21] count_error.
// A nonzero bin that is not equal to the total runs in the back end through
// a serial restoring divide, two serial log2 passes (one squaring per
// fraction bit) and a two-part multiply, then accumulate. Zero, full or
// error bins go straight to accumulate. A two-entry queue decouples input
// acceptance from the back end. A result is registered as the back end leaves
// the output state. Reset clears the sum, the error flag, the queue and tvalid.
// If the receiver stalls, the result is held and the back end waits before
// finishing the next last bin; the queue fills, then s_axis_tready drops.
module histogram_entropy_accumulator #(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bin_count
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // entropy_q16, count_error, zero pad
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import hea_pkg::*;

    logic [31:0] r_total;
    logic   w_qv, w_pop, w_busy;
    t_entry w_qd;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_total <= 32'd1;
        else if (i_cfg_we) r_total <= i_cfg_wdata;
    end

    hea_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tlast, .i_total(r_total), .o_q_valid(w_qv), .o_q_data(w_qd),
        .i_q_pop(w_pop)
    );

    hea_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(w_qv), .i_q_data(w_qd), .o_q_pop(w_pop),
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .o_busy(w_busy)
    );

    // The queue is only drained while the back end is idle.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_busy) else $error("pop while busy");
    // An error result always carries a zero entropy value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[21]) |-> (m_axis_tdata[20:0] == '0))
        else $error("error result not zero");
    // A pop only happens when the queue holds an entry.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv) else $error("pop from empty queue");
endmodule
